/* hdl/bdfd_pkg.sv */
`timescale 1ns / 1ps
package bdfd_pkg;
  localparam int unsigned FilterBits = 1048576;
  localparam int unsigned IdxW = $clog2(FilterBits);
  localparam int unsigned ProbeCount = 10;
  localparam int unsigned ProbeW = $clog2(ProbeCount + 1);
  localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
  localparam logic [1:0] FUNC_QUERY = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_FREE = 2'd2;
  localparam logic [0:0] REG_ENABLED = 1'b0;
  localparam int unsigned QDepth = 2;

  // classified work for the back end
  typedef struct packed {
    logic do_check;
    logic do_insert;
    logic [IdxW-1:0] h1;
    logic [IdxW-1:0] h2;
  } job_t;

  // one FNV-1a byte step; multiply by 2^40 + 0x1b3 as shift plus narrow product
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    begin
      x = h ^ {56'd0, b};
      fnv_step = (x << 40) + (x * 64'h1b3);
    end
  endfunction
endpackage

/* hdl/bdfd_front.sv */
`timescale 1ns / 1ps
module bdfd_front (
  input  logic clk,
  input  logic rst_n,
  input  logic enabled,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [71:0] in_tdata,
  output logic job_valid,
  input  logic job_ready,
  output bdfd_pkg::job_t job
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HASH = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [63:0] h_r, h_nxt, word_r, word_nxt;
  logic [bdfd_pkg::IdxW-1:0] h1_r, h1_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic pass_r, pass_nxt, chk_r, chk_nxt, ins_r, ins_nxt;
  logic [1:0] func;
  logic [63:0] addr;

  assign func = in_tdata[1:0];
  assign addr = in_tdata[65:2];
  assign in_tready = (state_r == S_IDLE);
  assign job_valid = (state_r == S_DONE);
  assign job.do_check = chk_r;
  assign job.do_insert = ins_r;
  assign job.h1 = h1_r;
  assign job.h2 = h_r[bdfd_pkg::IdxW-1:0];

  // classify, then hash the eight bytes one FNV byte step at a time, for each of the two passes
  always_comb begin
    state_nxt = state_r; h_nxt = h_r; word_nxt = word_r; h1_nxt = h1_r;
    cnt_nxt = cnt_r; pass_nxt = pass_r; chk_nxt = chk_r; ins_nxt = ins_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin
        chk_nxt = (addr != 64'd0) && enabled &&
                  (func == bdfd_pkg::FUNC_QUERY || func == bdfd_pkg::FUNC_FREE);
        ins_nxt = (addr != 64'd0) && (func == bdfd_pkg::FUNC_INSERT ||
                  (func == bdfd_pkg::FUNC_FREE && enabled));
        word_nxt = addr; h_nxt = bdfd_pkg::FnvBasis; cnt_nxt = 4'd0;
        pass_nxt = 1'b0; state_nxt = S_HASH;
      end
      S_HASH: begin
        h_nxt = bdfd_pkg::fnv_step(h_r, word_r[7:0]);
        word_nxt = word_r >> 8;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd7) begin
          cnt_nxt = 4'd0;
          if (!pass_r) begin
            h1_nxt = h_nxt[bdfd_pkg::IdxW-1:0]; word_nxt = h_nxt;
            h_nxt = bdfd_pkg::FnvBasis;
            pass_nxt = 1'b1;
          end else state_nxt = S_DONE;
        end
      end
      S_DONE: if (job_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
    h_r <= h_nxt; word_r <= word_nxt; h1_r <= h1_nxt; cnt_r <= cnt_nxt;
    pass_r <= pass_nxt; chk_r <= chk_nxt; ins_r <= ins_nxt;
  end

  a_done_after_hash: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(job_valid) |-> $past(state_r) == S_HASH) else $error("job without hash");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("second accept while hashing");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && !job_ready |=> job_valid) else $error("job dropped");
endmodule

/* hdl/bdfd_queue.sv */
`timescale 1ns / 1ps
module bdfd_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  bdfd_pkg::job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output bdfd_pkg::job_t rd_data
);
  bdfd_pkg::job_t mem_r [bdfd_pkg::QDepth];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];

  // push and pop pointers with occupancy count
  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue overflow");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !wr_ready) else $error("full not reported");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> (wp_r == rp_r)) else $error("pointer skew");
endmodule

/* hdl/bdfd_back.sv */
`timescale 1ns / 1ps
module bdfd_back (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_ready,
  input  bdfd_pkg::job_t job,
  output logic out_tvalid,
  input  logic out_tready,
  output logic [7:0] out_tdata
);
  localparam int unsigned IdxW = bdfd_pkg::IdxW;
  localparam int unsigned FilterBits = bdfd_pkg::FilterBits;
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CHK = 3'd2;
  localparam logic [2:0] S_CHKW = 3'd3;
  localparam logic [2:0] S_SET = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic mem [FilterBits];
  logic [2:0] state_r, state_nxt;
  logic [IdxW-1:0] p_r, p_nxt, h2_r, h2_nxt, base_r, base_nxt;
  logic [IdxW:0] clr_r, clr_nxt;
  logic [bdfd_pkg::ProbeW-1:0] i_r, i_nxt;
  logic ins_r, ins_nxt, hit_r, hit_nxt, insd_r, insd_nxt;
  logic rd_bit_r, we;
  logic [IdxW-1:0] waddr;
  logic wdata;

  assign job_ready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {6'd0, insd_r, hit_r};

  // store with one write port and one registered read port: clear sweep, probe reads, probe writes
  always_comb begin
    state_nxt = state_r; p_nxt = p_r; h2_nxt = h2_r; base_nxt = base_r;
    clr_nxt = clr_r; i_nxt = i_r; ins_nxt = ins_r; hit_nxt = hit_r; insd_nxt = insd_r;
    we = 1'b0; waddr = p_r; wdata = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_r[IdxW-1:0]; wdata = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (IdxW+1)'(FilterBits - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (job_valid) begin
        p_nxt = job.h1; base_nxt = job.h1; h2_nxt = job.h2; i_nxt = '0;
        ins_nxt = job.do_insert; hit_nxt = 1'b0; insd_nxt = 1'b0;
        if (job.do_check) state_nxt = S_CHK;
        else if (job.do_insert) state_nxt = S_SET;
        else state_nxt = S_OUT;
      end
      S_CHK: state_nxt = S_CHKW;
      S_CHKW: begin
        if (!rd_bit_r) begin
          p_nxt = base_r; i_nxt = '0;
          state_nxt = ins_r ? S_SET : S_OUT;
        end else if (i_r == bdfd_pkg::ProbeW'(bdfd_pkg::ProbeCount - 1)) begin
          hit_nxt = 1'b1; state_nxt = S_OUT;
        end else begin
          p_nxt = p_r + h2_r; i_nxt = i_r + 1'b1; state_nxt = S_CHK;
        end
      end
      S_SET: begin
        we = 1'b1;
        p_nxt = p_r + h2_r; i_nxt = i_r + 1'b1;
        if (i_r == bdfd_pkg::ProbeW'(bdfd_pkg::ProbeCount - 1)) begin
          insd_nxt = 1'b1; state_nxt = S_OUT;
        end
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_bit_r <= mem[p_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt;
    end
    p_r <= p_nxt; h2_r <= h2_nxt; base_r <= base_nxt; i_r <= i_nxt;
    ins_r <= ins_nxt; hit_r <= hit_nxt; insd_r <= insd_nxt;
  end

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(hit_r && insd_r)) else $error("hit and insert together");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("result lost");
  a_no_job_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !job_ready) else $error("job during clear");
endmodule

/* hdl/bloom_double_free_detector_top.sv */
`timescale 1ns / 1ps
// Channel  | Direction | Payload
// in_      | in        | tdata: func[1:0], address[65:2], zero pad to 72
// out_     | out       | tdata: hit[0], inserted[1], zero pad to 8
// cfg_     | APB       | reg 0 at 0x0: enabled[0]
// The front end takes each item through accept, 16 FNV byte steps and handoff, one at a time.
// The back end takes a job, reads each probe in S_CHK then S_CHKW, writes each probe in S_SET
// and presents the result in S_OUT; the two overlap through a 2-deep queue.
// After reset the back end clears all 1048576 filter bits, one bit a cycle.
// Either stream side may stall at any time; items wait in the queue.
module bloom_double_free_detector_top (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [71:0] in_tdata,   // func[1:0], address[65:2], zero pad
  output logic out_tvalid,
  input  logic out_tready,
  output logic [7:0] out_tdata,   // hit[0], inserted[1], zero pad
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [0:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  logic enabled_r;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  bdfd_pkg::job_t fj, bj;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, enabled_r};

  // register write on access phase
  always_ff @(posedge clk) begin
    if (!rst_n) enabled_r <= 1'b1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == bdfd_pkg::REG_ENABLED)
      enabled_r <= cfg_pwdata[0];
  end

  bdfd_front u_front (.clk, .rst_n, .enabled(enabled_r), .in_tvalid, .in_tready,
    .in_tdata, .job_valid(fj_valid), .job_ready(fj_ready), .job(fj));
  bdfd_queue u_queue (.clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready),
    .wr_data(fj), .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj));
  bdfd_back u_back (.clk, .rst_n, .job_valid(bj_valid), .job_ready(bj_ready),
    .job(bj), .out_tvalid, .out_tready, .out_tdata);
endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [63:0] FNV_PRIME = 64'h100000001b3;
  localparam int unsigned IDLE_LIMIT = 3000000;
  localparam int unsigned ITEMS_PER_PHASE = 225;

  typedef struct {
    logic hit;
    logic inserted;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [71:0] in_tdata;   // func[1:0], address[65:2], zero pad
  logic out_tvalid;
  logic out_tready;
  logic [7:0] out_tdata;   // hit[0], inserted[1], zero pad
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [0:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // shadow of the block: filter bits and the enable register
  bit shadow_filter [bdfd_pkg::FilterBits];
  logic shadow_enabled;
  verdict_t pending_verdicts[$];

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned idle_cycles;
  logic [63:0] addr_pool [24];

  bloom_double_free_detector_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // FNV-1a over the eight bytes of a word, low byte first
  function automatic logic [63:0] fnv_hash(input logic [63:0] word);
    logic [63:0] h;
    h = 64'hcbf29ce484222325;
    for (int k = 0; k < 8; k++) begin
      h = (h ^ {56'd0, word[8*k +: 8]}) * FNV_PRIME;
    end
    return h;
  endfunction

  // apply one transaction to the shadow filter and return the expected verdict
  function automatic verdict_t predict_verdict(input logic [1:0] func, input logic [63:0] addr);
    verdict_t v;
    logic [63:0] h1;
    logic [63:0] h2;
    logic [63:0] p;
    bit all_set;
    v.hit = 1'b0;
    v.inserted = 1'b0;
    if (addr == 64'd0 || func == FUNC_UNUSED) return v;
    h1 = fnv_hash(addr);
    h2 = fnv_hash(h1);
    all_set = 1'b1;
    for (int i = 0; i < bdfd_pkg::ProbeCount; i++) begin
      p = h1 + 64'(i) * h2;
      if (!shadow_filter[p[bdfd_pkg::IdxW-1:0]]) all_set = 1'b0;
    end
    if (func == bdfd_pkg::FUNC_QUERY) begin
      v.hit = shadow_enabled & all_set;
    end else if (func == bdfd_pkg::FUNC_INSERT || (shadow_enabled && !all_set)) begin
      for (int i = 0; i < bdfd_pkg::ProbeCount; i++) begin
        p = h1 + 64'(i) * h2;
        shadow_filter[p[bdfd_pkg::IdxW-1:0]] = 1'b1;
      end
      v.inserted = 1'b1;
    end else if (shadow_enabled) begin
      v.hit = 1'b1;
    end
    return v;
  endfunction

  function automatic void note_mismatch(input string what, input logic [63:0] expv,
                                        input logic [63:0] actv);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h, got %0h at %0t", what, expv, actv, $realtime);
  endfunction

  // receiver: random stall, check each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          note_mismatch("unexpected result", 64'd0, {56'd0, out_tdata});
        end else begin
          verdict_t v;
          v = pending_verdicts.pop_front();
          if (out_tdata[0] !== v.hit)
            note_mismatch("hit", {63'd0, v.hit}, {63'd0, out_tdata[0]});
          if (out_tdata[1] !== v.inserted)
            note_mismatch("inserted", {63'd0, v.inserted}, {63'd0, out_tdata[1]});
          if (out_tdata[7:2] !== 6'd0)
            note_mismatch("pad", 64'd0, {58'd0, out_tdata[7:2]});
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: count cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // send one item; each cycle before it the sender may idle with the drawn odds
  task automatic send_item(input logic [1:0] func, input logic [63:0] addr);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, addr, func};
    do @(posedge clk); while (!in_tready);
    pending_verdicts.push_back(predict_verdict(func, addr));
    items_sent++;
  endtask

  // stop sending and wait until every result has come back
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_enabled(input logic value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= bdfd_pkg::REG_ENABLED;
    cfg_pwdata <= {31'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    shadow_enabled = value;
    // read back the register
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[0] !== value)
      note_mismatch("enabled readback", {63'd0, value}, {63'd0, cfg_prdata[0]});
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // extremes, every func, zero address, double free, disabled behavior
  task automatic test_directed;
    send_item(bdfd_pkg::FUNC_QUERY, 64'd1);
    send_item(bdfd_pkg::FUNC_QUERY, '1);
    send_item(bdfd_pkg::FUNC_INSERT, 64'd1);
    send_item(bdfd_pkg::FUNC_QUERY, 64'd1);
    send_item(bdfd_pkg::FUNC_FREE, 64'd1);
    send_item(bdfd_pkg::FUNC_FREE, '1);
    send_item(bdfd_pkg::FUNC_FREE, '1);
    send_item(bdfd_pkg::FUNC_QUERY, '1);
    send_item(bdfd_pkg::FUNC_QUERY, 64'd0);
    send_item(bdfd_pkg::FUNC_INSERT, 64'd0);
    send_item(bdfd_pkg::FUNC_FREE, 64'd0);
    send_item(FUNC_UNUSED, 64'h8000_0000_0000_0000);
    send_item(bdfd_pkg::FUNC_QUERY, 64'h8000_0000_0000_0000);
    send_item(FUNC_UNUSED, 64'd0);
    send_item(bdfd_pkg::FUNC_FREE, 64'h0000_7fff_dead_beef);
    drain();
    write_enabled(1'b0);
    send_item(bdfd_pkg::FUNC_QUERY, 64'd1);
    send_item(bdfd_pkg::FUNC_FREE, 64'd1);
    send_item(bdfd_pkg::FUNC_FREE, 64'h1234_5678_9abc_def0);
    send_item(bdfd_pkg::FUNC_INSERT, 64'h1234_5678_9abc_def0);
    send_item(bdfd_pkg::FUNC_INSERT, 64'd0);
    drain();
    write_enabled(1'b1);
    send_item(bdfd_pkg::FUNC_QUERY, 64'h1234_5678_9abc_def0);
    send_item(bdfd_pkg::FUNC_FREE, 64'h1234_5678_9abc_def0);
    drain();
  endtask

  // random ops drawn mostly from a small pool so that hits and double frees occur
  task automatic test_random(input int unsigned gap_pct, input int unsigned stall_pct,
                             input logic en);
    logic [1:0] func;
    logic [63:0] addr;
    int unsigned r;
    write_enabled(en);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      r = $urandom_range(99);
      if (r < 55) addr = addr_pool[$urandom_range(23)];
      else if (r < 93) addr = {$urandom, $urandom};
      else if (r < 97) addr = 64'd0;
      else addr = ~(64'd1 << $urandom_range(63));
      r = $urandom_range(99);
      if (r < 40) func = bdfd_pkg::FUNC_FREE;
      else if (r < 70) func = bdfd_pkg::FUNC_QUERY;
      else if (r < 95) func = bdfd_pkg::FUNC_INSERT;
      else func = FUNC_UNUSED;
      send_item(func, addr);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    shadow_enabled = 1'b1;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    idle_cycles = 0;
    foreach (addr_pool[i]) addr_pool[i] = {$urandom, $urandom} | 64'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(0, 0, 1'b1);
    test_random(63, 0, 1'b1);
    test_random(0, 63, 1'b0);
    test_random(19, 19, 1'b1);

    if (pending_verdicts.size() != 0) begin
      $display("%0d results never arrived", pending_verdicts.size());
      mismatches++;
    end
    $display("ran %0d items (query, insert, free, unused func, zero address) with",
             items_sent);
    $display("enable toggled and four idle/stall mixes; %0d results checked", results_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
